// ===== design/dmf_pkg.sv =====
// Shared types, constants and register indexes for the distance map fusion block.
package dmf_pkg;

    localparam int NodeCount  = 65536;
    localparam int NodeBits   = 16;
    localparam int CfgIdxBits = 2;
    localparam int CfgDataW   = 17;
    localparam int ClearCnt   = NodeCount / 32;
    localparam int ClearBits  = $clog2(ClearCnt);

    typedef enum logic [CfgIdxBits-1:0] {
        REG_MODE        = 2'd0,
        REG_INIT_DIST   = 2'd1,
        REG_INIT_WEIGHT = 2'd2,
        REG_ACTIVE      = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MODE_AVERAGE = 2'd0,
        MODE_CONVEX  = 2'd1,
        MODE_UNION   = 2'd2,
        MODE_NONE    = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_FUSE,
        ST_DIV,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic [15:0]        node_index;
        logic signed [15:0] new_distance;
        logic [15:0]        new_weight;
    } in_item_t;

    typedef struct packed {
        logic [15:0]        out_node;
        logic signed [15:0] fused_distance;
        logic [15:0]        fused_weight;
        logic               index_error;
    } out_item_t;

endpackage

// ===== design/dmf_divider.sv =====
// Restoring signed divider: 34-bit dividend by 17-bit divisor, one quotient bit a cycle.
module dmf_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    input  logic signed [33:0] dividend,
    input  logic [16:0]        divisor,
    output logic               done,
    output logic signed [15:0] quotient
);
    import dmf_pkg::*;

    logic [33:0] quo_reg, quo_next;
    logic [16:0] rem_reg, rem_next;
    logic [16:0] dvs_reg, dvs_next;
    logic        neg_reg, neg_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [17:0] trial;
    logic [33:0] neg_q;

    // one bit of restoring division per cycle
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[33]} - {1'b0, dvs_reg};
        if (go)
        begin
            quo_next = dividend[33] ? 34'(-dividend) : dividend;
            rem_next = '0;
            dvs_next = divisor;
            neg_next = dividend[33];
            cnt_next = 6'd34;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (!trial[17])
            begin
                rem_next = trial[16:0];
                quo_next = {quo_reg[32:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[15:0], quo_reg[33]};
                quo_next = {quo_reg[32:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign neg_q    = 34'(-quo_reg);
    assign done     = done_reg;
    assign quotient = neg_reg ? neg_q[15:0] : quo_reg[15:0];

endmodule

// ===== design/distance_map_fusion.sv =====
// Distance map fusion top level: node store, written flags, fusion control.
// Sequence: IDLE, READ, FUSE, WRITE for convex, union and unused modes; index errors
// answer from IDLE; weighted average adds DIV (serial 34-bit divider) before WRITE.
// Throughput: one item at a time; next start can be taken in the result's own cycle.
// Reset: asynchronous active low; registers to defaults, then a pass over all 2048
// rows clears the written flags (32 per row) with busy high. No output stall.
module distance_map_fusion (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  dmf_pkg::in_item_t          in_item,
    output logic                       strobe,
    output dmf_pkg::out_item_t         out_item,
    input  logic                       cfg_we,
    input  logic [dmf_pkg::CfgIdxBits-1:0] cfg_index,
    input  logic [dmf_pkg::CfgDataW-1:0]   cfg_data
);
    import dmf_pkg::*;

    // configuration registers
    mode_t              mode_reg;
    logic signed [15:0] init_dist_reg;
    logic [15:0]        init_weight_reg;
    logic [16:0]        active_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_AVERAGE;
            init_dist_reg   <= '0;
            init_weight_reg <= '0;
            active_reg      <= 17'(NodeCount);
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_MODE:        mode_reg        <= mode_t'(cfg_data[1:0]);
                REG_INIT_DIST:   init_dist_reg   <= cfg_data[15:0];
                REG_INIT_WEIGHT: init_weight_reg <= cfg_data[15:0];
                REG_ACTIVE:      active_reg      <= cfg_data;
                default:         ;
            endcase
        end
    end

    // memories: data store and written-flag rows of 32
    logic [31:0] data_mem [NodeCount];
    logic [31:0] flag_mem [ClearCnt];
    logic [31:0] data_rd, flag_rd;

    state_t state_reg, state_next;
    in_item_t item_reg, item_next;
    logic [ClearBits-1:0] clr_reg, clr_next;
    logic signed [15:0] d_reg, d_next;
    logic [15:0]        w_reg, w_next;
    logic               err_reg, err_next;
    out_item_t          res_reg, res_next;
    logic               strobe_reg, strobe_next;

    logic               mem_we, flag_we;
    logic [ClearBits-1:0] flag_addr;
    logic [31:0]        flag_wdata;
    logic [31:0]        data_wdata;

    logic [4:0]         bit_sel;
    logic               was_written;
    logic signed [15:0] cur_d, n;
    logic [15:0]        cur_w, v;
    logic [16:0]        wsum;
    logic signed [33:0] num;
    logic               div_go, div_done;
    logic signed [15:0] div_q;
    logic signed [16:0] mag_d, mag_n;

    assign bit_sel     = item_reg.node_index[4:0];
    assign was_written = flag_rd[bit_sel];
    assign cur_d       = was_written ? data_rd[31:16] : init_dist_reg;
    assign cur_w       = was_written ? data_rd[15:0] : init_weight_reg;
    assign n           = item_reg.new_distance;
    assign v           = item_reg.new_weight;
    assign mag_d       = d_reg[15] ? -17'(d_reg) : 17'(d_reg);
    assign mag_n       = n[15] ? -17'(n) : 17'(n);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            data_mem[item_reg.node_index] <= data_wdata;
        data_rd <= data_mem[item_reg.node_index];
        if (flag_we)
            flag_mem[flag_addr] <= flag_wdata;
        flag_rd <= flag_mem[flag_addr];
    end

    // product stage: register the 16x16 products before the divider
    logic signed [31:0] pd_reg, pn_reg;
    always_ff @(posedge clk)
    begin
        pd_reg <= d_next * $signed({1'b0, w_next});
        pn_reg <= n * $signed({1'b0, v});
    end
    assign wsum = 17'(w_reg) + 17'(v);
    assign num  = 34'(pd_reg) + 34'(pn_reg);

    dmf_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go),
        .dividend (num),
        .divisor  (wsum),
        .done     (div_done),
        .quotient (div_q)
    );

    // control sequence
    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        clr_next    = clr_reg;
        d_next      = d_reg;
        w_next      = w_reg;
        err_next    = err_reg;
        res_next    = res_reg;
        strobe_next = 1'b0;
        mem_we      = 1'b0;
        flag_we     = 1'b0;
        flag_addr   = item_reg.node_index[15:5];
        flag_wdata  = flag_rd;
        flag_wdata[bit_sel] = 1'b1;
        data_wdata  = {d_reg, w_reg};
        div_go      = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                flag_we    = 1'b1;
                flag_addr  = clr_reg;
                flag_wdata = '0;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == ClearBits'(ClearCnt - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    item_next = in_item;
                    if (17'(in_item.node_index) >= active_reg)
                    begin
                        res_next    = '{in_item.node_index, 16'sd0, 16'd0, 1'b1};
                        strobe_next = 1'b1;
                    end
                    else
                        state_next = ST_READ;
                end
            end
            ST_READ:
                state_next = ST_FUSE;
            ST_FUSE:
            begin
                d_next     = cur_d;
                w_next     = cur_w;
                state_next = ST_WRITE;
                if (mode_reg == MODE_AVERAGE)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (!err_reg)
                begin
                    err_next = 1'b1;
                    div_go   = 1'b1;
                end
                else if (div_done)
                begin
                    err_next = 1'b0;
                    if (wsum != '0)
                        d_next = div_q;
                    w_next     = wsum[16:1];
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                logic signed [15:0] df;
                df = d_reg;
                case (mode_reg)
                    MODE_CONVEX:
                    begin
                        if (n > 0)
                        begin
                            if (d_reg < 0 || d_reg > n) df = n;
                        end
                        else if (d_reg < 0 && d_reg < n) df = n;
                    end
                    MODE_UNION:
                        if (n != 0 && (d_reg == 0 || mag_d > mag_n)) df = n;
                    default: ;
                endcase
                data_wdata = {df, w_reg};
                if (mode_reg != MODE_NONE)
                begin
                    mem_we  = 1'b1;
                    flag_we = 1'b1;
                end
                res_next    = '{item_reg.node_index, df, w_reg, 1'b0};
                strobe_next = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            strobe_reg <= 1'b0;
            err_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            strobe_reg <= strobe_next;
            err_reg    <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        d_reg    <= d_next;
        w_reg    <= w_next;
        res_reg  <= res_next;
    end

    assign busy     = (state_reg != ST_IDLE);
    assign strobe   = strobe_reg;
    assign out_item = res_reg;

    // checks
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && out_item.index_error |-> out_item.fused_distance == 0
            && out_item.fused_weight == 0)
        else $error("index error result carries data");
    a_write_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WRITE |=> strobe)
        else $error("write without result");
    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> busy)
        else $error("clear pass not busy");

endmodule

// ===== tb/distance_map_fusion_chk.sv =====
// Checker for the distance map fusion block: tracks the node store, predicts and compares.
module distance_map_fusion_chk (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  dmf_pkg::in_item_t              in_item,
    input  logic                           strobe,
    input  dmf_pkg::out_item_t             out_item,
    input  logic                           cfg_we,
    input  logic [dmf_pkg::CfgIdxBits-1:0] cfg_index,
    input  logic [dmf_pkg::CfgDataW-1:0]   cfg_data,
    output int                             fail_count,
    output int                             pending
);
    import dmf_pkg::*;

    // shadow store and registers
    logic signed [15:0] node_dist [NodeCount];
    logic [15:0]        node_wgt  [NodeCount];
    bit                 node_seen [NodeCount];
    mode_t              cur_mode;
    logic signed [15:0] cur_init_dist;
    logic [15:0]        cur_init_wgt;
    logic [16:0]        cur_active;
    out_item_t          fused_q [$];

    assign pending = fused_q.size();

    function automatic out_item_t fuse_node(in_item_t it);
        out_item_t          r;
        logic signed [15:0] d;
        logic [15:0]        w;
        logic signed [15:0] n;
        logic [16:0]        s;
        longint             num;
        int                 mag_d;
        int                 mag_n;
        n = it.new_distance;
        r.out_node = it.node_index;
        r.index_error = 1'b0;
        if ({1'b0, it.node_index} >= cur_active) begin
            r.fused_distance = '0;
            r.fused_weight = '0;
            r.index_error = 1'b1;
            return r;
        end
        d = node_seen[it.node_index] ? node_dist[it.node_index] : cur_init_dist;
        w = node_seen[it.node_index] ? node_wgt[it.node_index] : cur_init_wgt;
        case (cur_mode)
            MODE_AVERAGE:
            begin
                s = {1'b0, w} + {1'b0, it.new_weight};
                if (s != 0)
                begin
                    num = longint'(d) * longint'(w) + longint'(n) * longint'(it.new_weight);
                    d = 16'(num / longint'(s));
                end
                w = s[16:1];
            end
            MODE_CONVEX:
            begin
                if (n > 0)
                begin
                    if (d < 0 || d > n) d = n;
                end
                else if (d < 0 && d < n) d = n;
            end
            MODE_UNION:
            begin
                mag_d = (d < 0) ? -int'(d) : int'(d);
                mag_n = (n < 0) ? -int'(n) : int'(n);
                if (n != 0 && (d == 0 || mag_d > mag_n)) d = n;
            end
            default: ;
        endcase
        if (cur_mode != MODE_NONE)
        begin
            node_dist[it.node_index] = d;
            node_wgt[it.node_index] = w;
            node_seen[it.node_index] = 1'b1;
        end
        r.fused_distance = d;
        r.fused_weight = w;
        return r;
    endfunction

    // watch configuration, accepted beats and results
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            cur_mode = MODE_AVERAGE;
            cur_init_dist = '0;
            cur_init_wgt = '0;
            cur_active = 17'd65536;
            foreach (node_seen[i]) node_seen[i] = 1'b0;
            fused_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (strobe)
            begin
                if (fused_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result beat: %p", out_item);
                end
                else
                begin
                    want = fused_q.pop_front();
                    if (want !== out_item)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %p, got %p", want, out_item);
                    end
                end
            end
            if (cfg_we)
                case (cfg_reg_t'(cfg_index))
                    REG_MODE:        cur_mode = mode_t'(cfg_data[1:0]);
                    REG_INIT_DIST:   cur_init_dist = cfg_data[15:0];
                    REG_INIT_WEIGHT: cur_init_wgt = cfg_data[15:0];
                    REG_ACTIVE:      cur_active = cfg_data;
                    default: ;
                endcase
            if (start && !busy)
                fused_q.push_back(fuse_node(in_item));
        end
    end

endmodule

// ===== tb/distance_map_fusion_tb.sv =====
// Testbench top for the distance map fusion block: clock, reset, stimulus and verdict.
module distance_map_fusion_tb;
    import dmf_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    in_item_t              in_item;
    logic                  strobe;
    out_item_t             out_item;
    logic                  cfg_we;
    logic [CfgIdxBits-1:0] cfg_index;
    logic [CfgDataW-1:0]   cfg_data;
    int                    fail_count;
    int                    pending;
    int                    idle_pct;
    longint                cycle_count;

    distance_map_fusion dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
        .strobe(strobe), .out_item(out_item), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    distance_map_fusion_chk chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
        .strobe(strobe), .out_item(out_item), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // watchdog: ends the run as a failure if 948 items plus the clearing pass overrun
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 400000)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [CfgDataW-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // one command beat, with random idle ahead of it; start left low afterwards
    task automatic send_node(logic [15:0] node, logic [15:0] new_dist, logic [15:0] wgt);
        while ($urandom_range(99) < idle_pct) @(posedge clk);
        start <= 1'b1;
        in_item <= '{node_index: node, new_distance: new_dist, new_weight: wgt};
        @(posedge clk);
        while (busy) @(posedge clk);
        start <= 1'b0;
        @(posedge clk);
    endtask

    // let the block drain before touching registers
    task automatic drain;
        while (pending != 0 || busy) @(posedge clk);
        repeat (45) @(posedge clk);
    endtask

    task automatic random_batch(int count, int node_span);
        logic [15:0] node;
        logic [15:0] new_dist;
        for (int i = 0; i < count; i++)
        begin
            idle_pct = (i % 150 < 50) ? 0 : ((i % 150 < 100) ? 50 : 32);
            node = 16'($urandom_range(node_span - 1));
            if ($urandom_range(9) == 0) node = 16'($urandom);
            new_dist = 16'($urandom);
            case ($urandom_range(5))
                0: new_dist = 16'h8000;
                1: new_dist = 16'h7FFF;
                2: new_dist = 16'h0000;
                default: ;
            endcase
            send_node(node, new_dist, ($urandom_range(3) == 0) ? 16'h0 : 16'($urandom));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        in_item = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        idle_pct = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);

        // directed: average with zero weights, extremes, never-written nodes
        send_node(16'd0, 16'h7FFF, 16'h0000);
        send_node(16'd0, 16'h8000, 16'hFFFF);
        send_node(16'd0, 16'h7FFF, 16'hFFFF);
        send_node(16'hFFFF, 16'h8000, 16'h0001);
        drain();
        write_reg(REG_INIT_DIST, 17'h08000);
        write_reg(REG_INIT_WEIGHT, 17'h0FFFF);
        send_node(16'd5, 16'h7FFF, 16'hFFFF);
        send_node(16'd6, 16'h1234, 16'h0000);
        drain();
        write_reg(REG_MODE, 17'(MODE_CONVEX));
        send_node(16'd7, 16'h0010, 16'h0);
        send_node(16'd7, 16'h0008, 16'h0);
        send_node(16'd7, 16'h0020, 16'h0);
        send_node(16'd7, 16'hFFF0, 16'h0);
        send_node(16'd8, 16'h0000, 16'h0);
        drain();
        write_reg(REG_MODE, 17'(MODE_UNION));
        send_node(16'd9, 16'h0000, 16'h0);
        send_node(16'd9, 16'h7FFF, 16'h0);
        send_node(16'd10, 16'h8000, 16'h0);
        send_node(16'd10, 16'h7FFF, 16'h0);
        drain();
        write_reg(REG_MODE, 17'(MODE_NONE));
        send_node(16'd9, 16'h1111, 16'h2222);
        send_node(16'd200, 16'h1111, 16'h2222);
        drain();
        write_reg(REG_ACTIVE, 17'd0);
        send_node(16'd0, 16'h1111, 16'h2222);
        drain();
        write_reg(REG_ACTIVE, 17'd1);
        write_reg(REG_MODE, 17'(MODE_AVERAGE));
        send_node(16'd0, 16'h1111, 16'h2222);
        send_node(16'd1, 16'h1111, 16'h2222);
        drain();

        // random phases across settings; small node span in odd phases so nodes get revisited
        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(REG_MODE, 17'(ph % 4));
            write_reg(REG_INIT_DIST, (ph == 1) ? 17'h07FFF : 17'($urandom));
            write_reg(REG_INIT_WEIGHT, (ph == 2) ? 17'h00000 : 17'($urandom));
            write_reg(REG_ACTIVE, (ph % 3 == 0) ? 17'd65536 : 17'($urandom_range(1, 65535)));
            random_batch((ph % 4 == 3) ? 50 : 138, (ph % 2) ? 64 : 65536);
            drain();
        end

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
